[hw/rtl/hed_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hed_pkg
// Shared types, constants and the named-reference lookup of the entity decoder.
// ----------------------------------------------------------------------------
package hed_pkg;

   localparam int SPAN_DEFAULT = 12;
   localparam int RESULT_CAP   = 16;
   localparam int CAP_W        = $clog2(RESULT_CAP + 1);

   localparam logic [7:0] CHAR_AMP  = 8'h26;
   localparam logic [7:0] CHAR_SEMI = 8'h3B;
   localparam logic [7:0] CHAR_HASH = 8'h23;
   localparam logic [31:0] CP_MAX   = 32'h0010_FFFF;
   localparam logic [31:0] CP_REPL  = 32'h0000_FFFD;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
   } rsp_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_LOAD, OP_FETCH, OP_PASS, OP_START, OP_PUSH, OP_NAME_LOAD,
      OP_NUM_INIT, OP_NUM_STEP, OP_ENCODE, OP_EMIT_RES, OP_FAIL_INIT,
      OP_COPY_PEND, OP_COPY_EXTRA, OP_COPY_WORK, OP_FAIL_DONE, OP_FLUSH
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic emit_ok;
      logic flush_ok;
      logic pos_lt_len;
      logic last;
      logic in_entity;
      logic cur_amp;
      logic cur_semi;
      logic cnt_full;
      logic name_hit;
      logic num_start;
      logic i_lt_cnt;
      logic digit_bad;
      logic cp_zero;
      logic res_last;
   } stat_type;

   typedef struct packed {
      logic       hit;
      logic [2:0] n;
      logic [7:0] b0;
      logic [7:0] b1;
      logic [7:0] b2;
   } name_res_type;

   function automatic logic [7:0] to_lower(input logic [7:0] c);
      to_lower = (c >= 8'h41 && c <= 8'h5A) ? (c | 8'h20) : c;
   endfunction

   // win holds the lowercased name, first byte in win[0]
   function automatic name_res_type name_lookup(input logic [5:0][7:0] win,
                                                input logic [2:0] len);
      logic [47:0] word;
      logic [50:0] key;
      name_res_type r;
      word = '0;
      for (int j = 0; j < 6; j++) begin
         if (j < int'(len)) begin
            word[47-8*j -: 8] = win[j];
         end
      end
      key = {len, word};
      r = '0;
      r.hit = 1'b1;
      case (key)
         {3'd3, "amp", 24'd0}:    begin r.n = 3'd1; r.b0 = 8'h26; end
         {3'd2, "lt", 32'd0}:     begin r.n = 3'd1; r.b0 = 8'h3C; end
         {3'd2, "gt", 32'd0}:     begin r.n = 3'd1; r.b0 = 8'h3E; end
         {3'd4, "quot", 16'd0}:   begin r.n = 3'd1; r.b0 = 8'h22; end
         {3'd4, "apos", 16'd0}:   begin r.n = 3'd1; r.b0 = 8'h27; end
         {3'd4, "nbsp", 16'd0}:   begin r.n = 3'd2; r.b0 = 8'hC2; r.b1 = 8'hA0; end
         {3'd4, "copy", 16'd0}:   begin r.n = 3'd2; r.b0 = 8'hC2; r.b1 = 8'hA9; end
         {3'd3, "reg", 24'd0}:    begin r.n = 3'd2; r.b0 = 8'hC2; r.b1 = 8'hAE; end
         {3'd5, "trade", 8'd0}:   begin
            r.n = 3'd3; r.b0 = 8'hE2; r.b1 = 8'h84; r.b2 = 8'hA2;
         end
         {3'd6, "hellip"}:        begin
            r.n = 3'd3; r.b0 = 8'hE2; r.b1 = 8'h80; r.b2 = 8'hA6;
         end
         {3'd5, "mdash", 8'd0}:   begin
            r.n = 3'd3; r.b0 = 8'hE2; r.b1 = 8'h80; r.b2 = 8'h94;
         end
         {3'd5, "ndash", 8'd0}:   begin
            r.n = 3'd3; r.b0 = 8'hE2; r.b1 = 8'h80; r.b2 = 8'h93;
         end
         {3'd5, "lsquo", 8'd0}:   begin
            r.n = 3'd3; r.b0 = 8'hE2; r.b1 = 8'h80; r.b2 = 8'h98;
         end
         {3'd5, "rsquo", 8'd0}:   begin
            r.n = 3'd3; r.b0 = 8'hE2; r.b1 = 8'h80; r.b2 = 8'h99;
         end
         {3'd5, "ldquo", 8'd0}:   begin
            r.n = 3'd3; r.b0 = 8'hE2; r.b1 = 8'h80; r.b2 = 8'h9C;
         end
         {3'd5, "rdquo", 8'd0}:   begin
            r.n = 3'd3; r.b0 = 8'hE2; r.b1 = 8'h80; r.b2 = 8'h9D;
         end
         {3'd4, "bull", 16'd0}:   begin
            r.n = 3'd3; r.b0 = 8'hE2; r.b1 = 8'h80; r.b2 = 8'hA2;
         end
         {3'd6, "middot"}:        begin r.n = 3'd2; r.b0 = 8'hC2; r.b1 = 8'hB7; end
         {3'd3, "deg", 24'd0}:    begin r.n = 3'd2; r.b0 = 8'hC2; r.b1 = 8'hB0; end
         {3'd6, "plusmn"}:        begin r.n = 3'd2; r.b0 = 8'hC2; r.b1 = 8'hB1; end
         {3'd5, "times", 8'd0}:   begin r.n = 3'd2; r.b0 = 8'hC3; r.b1 = 8'h97; end
         {3'd6, "divide"}:        begin r.n = 3'd2; r.b0 = 8'hC3; r.b1 = 8'hB7; end
         {3'd4, "euro", 16'd0}:   begin
            r.n = 3'd3; r.b0 = 8'hE2; r.b1 = 8'h82; r.b2 = 8'hAC;
         end
         {3'd5, "pound", 8'd0}:   begin r.n = 3'd2; r.b0 = 8'hC2; r.b1 = 8'hA3; end
         {3'd3, "yen", 24'd0}:    begin r.n = 3'd2; r.b0 = 8'hC2; r.b1 = 8'hA5; end
         default:                 r.hit = 1'b0;
      endcase
      name_lookup = r;
   endfunction

endpackage

[hw/rtl/hed_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hed_ctrl
// Sequencer: walks the work queue one byte at a time and drives the datapath.
// ----------------------------------------------------------------------------
module hed_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  hed_pkg::stat_type stat,
   output hed_pkg::cmd_type  cmd
);
   import hed_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_FETCH, S_DISPATCH, S_NAME, S_NUM, S_ENC, S_EMIT,
      S_FAIL_AMP, S_COPY_PEND, S_COPY_WORK, S_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      extra_ff, extra_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      extra_in = extra_ff;
      cmd.op   = OP_NONE;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = S_FETCH;
            end
         end
         S_FETCH: begin
            if (stat.pos_lt_len) begin
               cmd.op   = OP_FETCH;
               state_in = S_DISPATCH;
            end else if (stat.last && stat.in_entity) begin
               extra_in = 1'b0;
               state_in = S_FAIL_AMP;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_DISPATCH: begin
            if (!stat.in_entity) begin
               if (stat.cur_amp) begin
                  cmd.op   = OP_START;
                  state_in = S_FETCH;
               end else begin
                  cmd.op = OP_PASS;
                  if (stat.emit_ok) state_in = S_FETCH;
               end
            end else if (stat.cur_semi) begin
               state_in = S_NAME;
            end else if (!stat.cnt_full) begin
               cmd.op   = OP_PUSH;
               state_in = S_FETCH;
            end else begin
               extra_in = 1'b1;
               state_in = S_FAIL_AMP;
            end
         end
         S_NAME: begin
            if (stat.name_hit) begin
               cmd.op   = OP_NAME_LOAD;
               state_in = S_EMIT;
            end else if (stat.num_start) begin
               cmd.op   = OP_NUM_INIT;
               state_in = S_NUM;
            end else begin
               extra_in = 1'b1;
               state_in = S_FAIL_AMP;
            end
         end
         S_NUM: begin
            if (!stat.i_lt_cnt) begin
               state_in = S_ENC;
            end else if (stat.digit_bad) begin
               extra_in = 1'b1;
               state_in = S_FAIL_AMP;
            end else begin
               cmd.op = OP_NUM_STEP;
            end
         end
         S_ENC: begin
            if (stat.cp_zero) begin
               extra_in = 1'b1;
               state_in = S_FAIL_AMP;
            end else begin
               cmd.op   = OP_ENCODE;
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            cmd.op = OP_EMIT_RES;
            if (stat.emit_ok && stat.res_last) state_in = S_FETCH;
         end
         S_FAIL_AMP: begin
            cmd.op = OP_FAIL_INIT;
            if (stat.emit_ok) state_in = S_COPY_PEND;
         end
         S_COPY_PEND: begin
            if (stat.i_lt_cnt) begin
               cmd.op = OP_COPY_PEND;
            end else begin
               if (extra_ff) cmd.op = OP_COPY_EXTRA;
               state_in = S_COPY_WORK;
            end
         end
         S_COPY_WORK: begin
            if (stat.pos_lt_len) begin
               cmd.op = OP_COPY_WORK;
            end else begin
               cmd.op   = OP_FAIL_DONE;
               state_in = S_FETCH;
            end
         end
         S_FINISH: begin
            cmd.op = OP_FLUSH;
            if (stat.flush_ok) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         extra_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         extra_ff <= extra_in;
      end
   end

endmodule

[hw/rtl/hed_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hed_datapath
// Work queue banks, pending name buffer, numeric accumulator, UTF-8 encoder
// and the result holding and output registers.
// ----------------------------------------------------------------------------
module hed_datapath #(
   parameter int MAX_ENTITY_SPAN = hed_pkg::SPAN_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  hed_pkg::req_type  req_data,
   input  hed_pkg::cmd_type  cmd,
   output hed_pkg::stat_type stat,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output hed_pkg::rsp_type  rsp_data
);
   import hed_pkg::*;

   localparam int WORK_LEN = MAX_ENTITY_SPAN + 1;
   localparam int CW       = $clog2(MAX_ENTITY_SPAN + 1);
   localparam int PIDX     = $clog2(MAX_ENTITY_SPAN);
   localparam int PW       = $clog2(WORK_LEN + 1);
   localparam int WIDX     = $clog2(WORK_LEN);

   logic [7:0]       pend_ff [MAX_ENTITY_SPAN];
   logic [7:0]       wk_ff [2][WORK_LEN];
   logic [CW-1:0]    cnt_ff, i_ff;
   logic [PW-1:0]    pos_ff, len_ff, t_ff;
   logic             ent_ff, last_ff, bank_ff, hex_ff;
   logic [7:0]       cur_ff;
   logic [31:0]      cp_ff;
   logic [7:0]       rb_ff [4];
   logic [2:0]       rn_ff;
   logic [1:0]       ri_ff;
   logic [CAP_W-1:0] n_ff;
   logic [7:0]       hold_ff;
   logic             hv_ff;
   logic             rsp_v_ff;
   rsp_type          rsp_ff;

   logic [5:0][7:0]  win;
   logic [2:0]       name_len;
   logic             name_short;
   name_res_type     name_res;
   logic [7:0]       pend_i, dig_c, lc, emit_byte;
   logic [3:0]       dig;
   logic             digit_bad;
   logic             out_free, emit_ok, do_emit, is_emit, rsp_push;
   logic [31:0]      cpc, cp_next;
   logic [CW-1:0]    len_c;

   // lowercased name window, first name byte follows the '&'
   for (genvar k = 0; k < 6; k++) begin : g_win
      if (k + 1 < MAX_ENTITY_SPAN) begin : g_on
         assign win[k] = to_lower(pend_ff[k+1]);
      end else begin : g_off
         assign win[k] = 8'h00;
      end
   end

   assign len_c      = cnt_ff - CW'(1);
   assign name_short = (cnt_ff != '0) && (len_c <= CW'(6));
   assign name_len   = len_c[2:0];
   assign name_res   = name_lookup(win, name_len);

   assign pend_i = pend_ff[i_ff[PIDX-1:0]];
   assign dig_c  = pend_i;
   assign lc     = dig_c | 8'h20;

   always_comb begin
      dig = 4'd0;
      digit_bad = 1'b0;
      if (dig_c >= 8'h30 && dig_c <= 8'h39) begin
         dig = 4'(dig_c - 8'h30);
      end else if (hex_ff && lc >= 8'h61 && lc <= 8'h66) begin
         dig = 4'(lc - 8'h57);
      end else begin
         digit_bad = 1'b1;
      end
   end

   assign cp_next = hex_ff ? {cp_ff[27:0], dig}
                           : ({cp_ff[28:0], 3'b000} + {cp_ff[30:0], 1'b0} + {28'd0, dig});
   assign cpc     = (cp_ff > CP_MAX) ? CP_REPL : cp_ff;

   assign out_free = !rsp_v_ff || rsp_ready;
   assign emit_ok  = (n_ff >= CAP_W'(RESULT_CAP)) || !hv_ff || out_free;
   assign is_emit  = (cmd.op == OP_PASS) || (cmd.op == OP_FAIL_INIT) ||
                     (cmd.op == OP_EMIT_RES);
   assign do_emit  = is_emit && emit_ok;
   // a beat moves from the holding register into the output register
   assign rsp_push = (do_emit && n_ff < CAP_W'(RESULT_CAP) && hv_ff) ||
                     (cmd.op == OP_FLUSH && hv_ff && out_free);

   always_comb begin
      case (cmd.op)
         OP_PASS:     emit_byte = cur_ff;
         OP_FAIL_INIT: emit_byte = CHAR_AMP;
         OP_EMIT_RES: emit_byte = rb_ff[ri_ff];
         default:     emit_byte = 8'h00;
      endcase
   end

   assign stat.emit_ok    = emit_ok;
   assign stat.flush_ok   = !hv_ff || out_free;
   assign stat.pos_lt_len = pos_ff < len_ff;
   assign stat.last       = last_ff;
   assign stat.in_entity  = ent_ff;
   assign stat.cur_amp    = cur_ff == CHAR_AMP;
   assign stat.cur_semi   = cur_ff == CHAR_SEMI;
   assign stat.cnt_full   = cnt_ff >= CW'(MAX_ENTITY_SPAN);
   assign stat.name_hit   = name_short && name_res.hit;
   assign stat.num_start  = (cnt_ff >= CW'(2)) && (pend_ff[1] == CHAR_HASH);
   assign stat.i_lt_cnt   = i_ff < cnt_ff;
   assign stat.digit_bad  = digit_bad;
   assign stat.cp_zero    = cp_ff == 32'd0;
   assign stat.res_last   = ({1'b0, ri_ff} + 3'd1) == rn_ff;

   assign rsp_valid = rsp_v_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= '0;
         ent_ff   <= 1'b0;
         last_ff  <= 1'b0;
         bank_ff  <= 1'b0;
         pos_ff   <= '0;
         len_ff   <= '0;
         n_ff     <= '0;
         hv_ff    <= 1'b0;
         rsp_v_ff <= 1'b0;
      end else begin
         if (rsp_push) rsp_v_ff <= 1'b1;
         else if (rsp_v_ff && rsp_ready) rsp_v_ff <= 1'b0;
         if (do_emit && n_ff < CAP_W'(RESULT_CAP)) begin
            if (hv_ff) begin
               rsp_ff <= '{out_byte: hold_ff, run_last: 1'b0};
            end
            hold_ff <= emit_byte;
            hv_ff   <= 1'b1;
            n_ff    <= n_ff + CAP_W'(1);
         end
         case (cmd.op)
            OP_LOAD: begin
               wk_ff[bank_ff][0] <= req_data.in_byte;
               len_ff  <= PW'(1);
               pos_ff  <= '0;
               last_ff <= req_data.end_of_text;
               n_ff    <= '0;
            end
            OP_FETCH: begin
               cur_ff <= wk_ff[bank_ff][pos_ff[WIDX-1:0]];
               pos_ff <= pos_ff + PW'(1);
            end
            OP_START: begin
               pend_ff[0] <= CHAR_AMP;
               cnt_ff     <= CW'(1);
               ent_ff     <= 1'b1;
            end
            OP_PUSH: begin
               pend_ff[cnt_ff[PIDX-1:0]] <= cur_ff;
               cnt_ff <= cnt_ff + CW'(1);
            end
            OP_NAME_LOAD: begin
               rb_ff[0] <= name_res.b0;
               rb_ff[1] <= name_res.b1;
               rb_ff[2] <= name_res.b2;
               rn_ff    <= name_res.n;
               ri_ff    <= 2'd0;
            end
            OP_NUM_INIT: begin
               cp_ff <= 32'd0;
               if (cnt_ff >= CW'(3) && (pend_ff[2] | 8'h20) == 8'h78) begin
                  hex_ff <= 1'b1;
                  i_ff   <= CW'(3);
               end else begin
                  hex_ff <= 1'b0;
                  i_ff   <= CW'(2);
               end
            end
            OP_NUM_STEP: begin
               cp_ff <= cp_next;
               i_ff  <= i_ff + CW'(1);
            end
            OP_ENCODE: begin
               ri_ff <= 2'd0;
               if (cpc < 32'h80) begin
                  rb_ff[0] <= cpc[7:0];
                  rn_ff    <= 3'd1;
               end else if (cpc < 32'h800) begin
                  rb_ff[0] <= 8'hC0 | {3'd0, cpc[10:6]};
                  rb_ff[1] <= 8'h80 | {2'd0, cpc[5:0]};
                  rn_ff    <= 3'd2;
               end else if (cpc < 32'h10000) begin
                  rb_ff[0] <= 8'hE0 | {4'd0, cpc[15:12]};
                  rb_ff[1] <= 8'h80 | {2'd0, cpc[11:6]};
                  rb_ff[2] <= 8'h80 | {2'd0, cpc[5:0]};
                  rn_ff    <= 3'd3;
               end else begin
                  rb_ff[0] <= 8'hF0 | {5'd0, cpc[20:18]};
                  rb_ff[1] <= 8'h80 | {2'd0, cpc[17:12]};
                  rb_ff[2] <= 8'h80 | {2'd0, cpc[11:6]};
                  rb_ff[3] <= 8'h80 | {2'd0, cpc[5:0]};
                  rn_ff    <= 3'd4;
               end
            end
            OP_EMIT_RES: begin
               if (emit_ok) begin
                  ri_ff <= ri_ff + 2'd1;
                  if (stat.res_last) begin
                     cnt_ff <= '0;
                     ent_ff <= 1'b0;
                  end
               end
            end
            OP_FAIL_INIT: begin
               t_ff <= '0;
               i_ff <= CW'(1);
            end
            OP_COPY_PEND: begin
               if (t_ff < PW'(WORK_LEN)) begin
                  wk_ff[!bank_ff][t_ff[WIDX-1:0]] <= pend_i;
                  t_ff <= t_ff + PW'(1);
               end
               i_ff <= i_ff + CW'(1);
            end
            OP_COPY_EXTRA: begin
               if (t_ff < PW'(WORK_LEN)) begin
                  wk_ff[!bank_ff][t_ff[WIDX-1:0]] <= cur_ff;
                  t_ff <= t_ff + PW'(1);
               end
            end
            OP_COPY_WORK: begin
               if (t_ff < PW'(WORK_LEN)) begin
                  wk_ff[!bank_ff][t_ff[WIDX-1:0]] <= wk_ff[bank_ff][pos_ff[WIDX-1:0]];
                  t_ff <= t_ff + PW'(1);
               end
               pos_ff <= pos_ff + PW'(1);
            end
            OP_FAIL_DONE: begin
               bank_ff <= !bank_ff;
               len_ff  <= t_ff;
               pos_ff  <= '0;
               cnt_ff  <= '0;
               ent_ff  <= 1'b0;
            end
            OP_FLUSH: begin
               if (hv_ff && out_free) begin
                  rsp_ff <= '{out_byte: hold_ff, run_last: 1'b1};
                  hv_ff  <= 1'b0;
               end
            end
            default: ;
         endcase
      end
   end

endmodule

[hw/rtl/html_entity_decoder_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// html_entity_decoder_core
// Streaming HTML character-reference decoder, one text byte per request beat.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_ready  | req_data (in_byte, end_of_text)
//  rsp     | out       | rsp_valid/rsp_ready  | rsp_data (out_byte, run_last)
//
// Sequencing: one item at a time. An item that passes or buffers its byte goes
// from accept to accept through fetch and dispatch of the byte, a fetch that
// finds the queue empty, a flush and the idle state with req_ready high. A
// closing ';' adds the name lookup and the emission of the result bytes; a
// numeric form starts in the lookup step, accumulates its digits in turn,
// ends the digits and encodes. A failed entity emits the '&', copies the
// buffered bytes after it and then the remaining queue bytes into the other
// bank, and walks that bank again, fetch and dispatch for each byte; the
// sequencer in hed_ctrl takes one queue byte per pass.
// Reset: synchronous; clears the sequencer, buffer count and output valid.
// Stalls: the last emitted byte is held back until the next one or the end
// of the item is known, so run_last can be set; a stalled rsp only halts
// emission, and req_ready returns once the item's final beat is registered.
// ----------------------------------------------------------------------------
module html_entity_decoder_core #(
   parameter int MAX_ENTITY_SPAN = hed_pkg::SPAN_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  hed_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output hed_pkg::rsp_type rsp_data
);
   import hed_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // sequencer: owns the walk over the work queue
   hed_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // storage, arithmetic and the output beat register
   hed_datapath #(
      .MAX_ENTITY_SPAN (MAX_ENTITY_SPAN)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

[hw/rtl/hed_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hed_checker
// Port-level checks of the entity decoder, bound to the top level.
// ----------------------------------------------------------------------------
module hed_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input hed_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input hed_pkg::rsp_type rsp_data
);
   import hed_pkg::*;

   // hold a stalled result beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp beat changed while stalled");

   // drop output valid at reset
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // one item in flight: ready falls after a request beat
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request taken while busy");

endmodule

bind html_entity_decoder_core hed_checker u_hed_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
